// ===== sv/additive_texture_layer_blend_assert.svh =====
// assertion macros for the blend block, empty when SYNTH is defined
`ifndef ADDITIVE_TEXTURE_LAYER_BLEND_ASSERT_SVH
`define ADDITIVE_TEXTURE_LAYER_BLEND_ASSERT_SVH

`ifndef SYNTH
`define ATLB_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("atlb check failed");
`define ATLB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("atlb check failed");
`else
`define ATLB_ASSERT_NOW(label, ante, cons)
`define ATLB_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== sv/atlb_pkg.sv =====
`timescale 1ns / 1ps

package atlb_pkg;

    localparam int IDX_W       = 14;
    localparam int BYTE_W      = 8;
    localparam int PROD_W      = 16;
    localparam int OUT_WIDE_W  = 24;
    localparam int COUNT_W     = 14;
    localparam int S_TDATA_W   = 32;
    localparam int M_TDATA_W   = 112;
    localparam int QUEUE_DEPTH = 2;
    localparam int LAYER_SHIFT = 7;

    localparam logic [15:0]        WHITE_WIDE = 16'd32640;
    localparam logic [15:0]        ROUND_HALF = 16'd64;
    localparam logic [BYTE_W-1:0]  BYTE_MAX   = 8'hFF;
    localparam logic [1:0]         ALPHA_LANE = 2'd3;
    localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;

    typedef enum logic [0:0] {
        REG_WIDE_BUF0 = 1'b0,
        REG_WIDE_BUF1 = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic              sel;
        logic              first;
        logic              wide_on;
        logic              alpha;
        logic              last;
        logic [BYTE_W-1:0] layer;
        logic [PROD_W-1:0] prod;
    } item_t;

    typedef struct packed {
        logic wide_on;
        logic alpha;
        logic last;
        logic over;
        logic differs;
    } tag_t;

endpackage

// ===== sv/additive_texture_layer_blend.sv =====
`timescale 1ns / 1ps
//
// channel   dir  tdata (low bit up)                                    tuser         tlast
// s_        in   first_draw, intensity, element_index, texel, 1 pad     buffer_sel    last_of_draw
// m_        out  legacy_value, wide_value, over_count, differs_count,   stats_valid   -
//                max_wide, max_dev, 4 pad
// cfg_      in   index 0 wide_mode_buffer0, index 1 wide_mode_buffer1 (bit 0 of cfg_wdata)
//
// one item per cycle unless the output stalls; path front, queue, stages a b c, output register
// the rate is held by the read-modify-write on the two buffer memories, forwarded one item back
// aresetn is synchronous; it clears handshake state and draw statistics, memories hold garbage
// until written and get no clearing pass
// m_tready low freezes the back pipeline; the two-entry queue then fills and s_tready drops
//
`include "additive_texture_layer_blend_assert.svh"

module additive_texture_layer_blend #(
    parameter int ELEMENT_COUNT = 16384,
    parameter int WIDE_BITS     = 24
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [atlb_pkg::S_TDATA_W-1:0]  s_tdata,    // first_draw, intensity, element_index, texel
    input  logic                            s_tuser,    // buffer_sel
    input  logic                            s_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [atlb_pkg::M_TDATA_W-1:0]  m_tdata,    // legacy_value, wide_value, over_count,
                                                        // differs_count, max_wide, max_dev
    output logic                            m_tuser,    // stats_valid
    input  logic                            cfg_we,
    input  logic [0:0]                      cfg_index,
    input  logic [0:0]                      cfg_wdata
);

    localparam int ADDR_LO_W = $clog2(ELEMENT_COUNT);
    localparam int ADDR_W    = ADDR_LO_W + 1;
    localparam int ITEM_W    = $bits(atlb_pkg::item_t);

    logic wide_buf0_reg;
    logic wide_buf1_reg;

    logic                    q_push;
    logic                    q_pop;
    logic                    q_full;
    logic                    q_valid;
    atlb_pkg::item_t         f_item;
    logic [ADDR_W-1:0]       f_addr;
    logic [ADDR_W+ITEM_W-1:0] q_data;
    atlb_pkg::item_t         q_item;
    logic [ADDR_W-1:0]       q_addr;

    logic                    out_advance;
    logic                    c_valid;
    atlb_pkg::tag_t          c_tag;
    logic [atlb_pkg::BYTE_W-1:0] c_lsum;
    logic [WIDE_BITS-1:0]    c_w;
    logic [WIDE_BITS-1:0]    c_d;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wide_buf0_reg <= 1'b0;
            wide_buf1_reg <= 1'b0;
        end else if (cfg_we) begin
            unique case (atlb_pkg::cfg_reg_t'(cfg_index))
                atlb_pkg::REG_WIDE_BUF0: wide_buf0_reg <= cfg_wdata[0];
                atlb_pkg::REG_WIDE_BUF1: wide_buf1_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    atlb_front #(
        .ELEMENT_COUNT (ELEMENT_COUNT),
        .ADDR_LO_W     (ADDR_LO_W)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .wide_buf0 (wide_buf0_reg),
        .wide_buf1 (wide_buf1_reg),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_item    (f_item),
        .q_addr    (f_addr)
    );

    atlb_queue #(
        .WIDTH (ADDR_W + ITEM_W),
        .DEPTH (atlb_pkg::QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data ({f_addr, f_item}),
        .pop       (q_pop),
        .full      (q_full),
        .valid     (q_valid),
        .data      (q_data)
    );

    assign q_item = atlb_pkg::item_t'(q_data[ITEM_W-1:0]);
    assign q_addr = q_data[ADDR_W+ITEM_W-1:ITEM_W];

    atlb_back #(
        .ADDR_W    (ADDR_W),
        .WIDE_BITS (WIDE_BITS)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (out_advance),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_addr  (q_addr),
        .q_pop   (q_pop),
        .c_valid (c_valid),
        .c_tag   (c_tag),
        .c_lsum  (c_lsum),
        .c_w     (c_w),
        .c_d     (c_d)
    );

    atlb_stats #(
        .WIDE_BITS (WIDE_BITS)
    ) u_stats (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .c_valid  (c_valid),
        .c_tag    (c_tag),
        .c_lsum   (c_lsum),
        .c_w      (c_w),
        .c_d      (c_d),
        .advance  (out_advance),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    `ATLB_ASSERT_NOW(a_stats_zero_outside_report, m_tvalid && !m_tuser, m_tdata[107:32] == '0)
    `ATLB_ASSERT_NOW(a_queue_no_overflow, q_push, !q_full)
    `ATLB_ASSERT_NEXT(a_queue_stays_full, q_full && !q_pop, q_full)

endmodule

// ===== sv/atlb_ram.sv =====
`timescale 1ns / 1ps

module atlb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/atlb_front.sv =====
`timescale 1ns / 1ps

module atlb_front #(
    parameter int ELEMENT_COUNT = 16384,
    parameter int ADDR_LO_W     = 14
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [atlb_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                             s_tuser,
    input  logic                             s_tlast,
    input  logic                             wide_buf0,
    input  logic                             wide_buf1,
    input  logic                             q_full,
    output logic                             q_push,
    output atlb_pkg::item_t                  q_item,
    output logic [ADDR_LO_W:0]               q_addr
);

    localparam int IDX_W = atlb_pkg::IDX_W;

    logic                       f_valid_reg;
    logic                       f_sel_reg;
    logic                       f_first_reg;
    logic                       f_wide_reg;
    logic                       f_last_reg;
    logic [atlb_pkg::BYTE_W-1:0] f_inten_reg;
    logic [atlb_pkg::BYTE_W-1:0] f_texel_reg;
    logic [IDX_W-1:0]           f_idx_reg;

    logic                        accept;
    logic [IDX_W-1:0]            in_idx;
    logic [ADDR_LO_W-1:0]        addr_lo;
    logic [atlb_pkg::PROD_W-1:0] prod;

    assign in_idx   = s_tdata[22:9];
    assign s_tready = !f_valid_reg || !q_full;
    assign accept   = s_tvalid && s_tready;
    assign q_push   = f_valid_reg && !q_full;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg <= 1'b0;
        end else if (s_tready) begin
            f_valid_reg <= s_tvalid;
        end
        if (accept) begin
            f_sel_reg   <= s_tuser;
            f_first_reg <= s_tdata[0];
            f_inten_reg <= s_tdata[8:1];
            f_idx_reg   <= in_idx;
            f_texel_reg <= s_tdata[30:23];
            f_last_reg  <= s_tlast;
            f_wide_reg  <= s_tuser ? wide_buf1 : wide_buf0;
        end
    end

    // index reduction modulo the buffer size
    if (ELEMENT_COUNT >= (1 << IDX_W)) begin : g_direct
        assign addr_lo = ADDR_LO_W'(f_idx_reg);
    end else begin : g_recip
        localparam int          SHIFT   = IDX_W + ADDR_LO_W;
        localparam int          RECIP_W = IDX_W + 1;
        localparam logic [63:0] RECIP   =
            ((64'd1 << SHIFT) + 64'(ELEMENT_COUNT) - 64'd1) / 64'(ELEMENT_COUNT);

        logic [IDX_W+RECIP_W-1:0] scaled;
        logic [IDX_W-1:0]         quot_reg;
        logic [IDX_W-1:0]         rem;

        assign scaled = (IDX_W+RECIP_W)'(in_idx) * (IDX_W+RECIP_W)'(RECIP);

        always_ff @(posedge aclk) begin
            if (accept) begin
                quot_reg <= IDX_W'(scaled >> SHIFT);
            end
        end

        assign rem     = f_idx_reg - IDX_W'(quot_reg * IDX_W'(ELEMENT_COUNT));
        assign addr_lo = ADDR_LO_W'(rem);
    end

    assign prod = atlb_pkg::PROD_W'(f_texel_reg) * atlb_pkg::PROD_W'(f_inten_reg);

    always_comb begin
        q_item.sel     = f_sel_reg;
        q_item.first   = f_first_reg;
        q_item.wide_on = f_wide_reg;
        q_item.alpha   = (f_idx_reg[1:0] == atlb_pkg::ALPHA_LANE);
        q_item.last    = f_last_reg;
        q_item.layer   = prod[15] ? atlb_pkg::BYTE_MAX : prod[14:7];
        q_item.prod    = prod;
    end

    assign q_addr = {f_sel_reg, addr_lo};

endmodule

// ===== sv/atlb_queue.sv =====
`timescale 1ns / 1ps

module atlb_queue #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic             full,
    output logic             valid,
    output logic [WIDTH-1:0] data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign valid = (count_reg != '0);
    assign data  = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
        end
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== sv/atlb_back.sv =====
`timescale 1ns / 1ps

module atlb_back #(
    parameter int ADDR_W    = 15,
    parameter int WIDE_BITS = 24
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          advance,
    input  logic                          q_valid,
    input  atlb_pkg::item_t               q_item,
    input  logic [ADDR_W-1:0]             q_addr,
    output logic                          q_pop,
    output logic                          c_valid,
    output atlb_pkg::tag_t                c_tag,
    output logic [atlb_pkg::BYTE_W-1:0]   c_lsum,
    output logic [WIDE_BITS-1:0]          c_w,
    output logic [WIDE_BITS-1:0]          c_d
);

    localparam int BYTE_W = atlb_pkg::BYTE_W;
    localparam logic [WIDE_BITS-1:0] WHITE = WIDE_BITS'(atlb_pkg::WHITE_WIDE);

    // stage a: read data arrives, sums formed, written back
    logic                 a_valid_reg;
    atlb_pkg::item_t      a_item_reg;
    logic [ADDR_W-1:0]    a_addr_reg;
    logic                 fwd_l_hit_reg;
    logic                 fwd_w_hit_reg;
    logic [BYTE_W-1:0]    fwd_l_reg;
    logic [WIDE_BITS-1:0] fwd_w_reg;

    // stage b: compare and distance
    logic                 b_valid_reg;
    atlb_pkg::tag_t       b_tag_reg;
    logic [BYTE_W-1:0]    b_lsum_reg;
    logic [WIDE_BITS-1:0] b_w_reg;

    // stage c: handed to the statistics unit
    logic                 c_valid_reg;
    atlb_pkg::tag_t       c_tag_reg;
    logic [BYTE_W-1:0]    c_lsum_reg;
    logic [WIDE_BITS-1:0] c_w_reg;
    logic [WIDE_BITS-1:0] c_d_reg;

    logic [BYTE_W-1:0]    l_rd_data;
    logic [WIDE_BITS-1:0] w_rd_data;
    logic [BYTE_W-1:0]    old_l;
    logic [WIDE_BITS-1:0] old_w;
    logic [BYTE_W:0]      l_sum;
    logic [WIDE_BITS:0]   w_sum;
    logic [WIDE_BITS-1:0] w_sat;
    logic [BYTE_W-1:0]    a_lsum;
    logic [WIDE_BITS-1:0] a_w;
    logic                 a_write;

    logic [WIDE_BITS-1:0] legacy_scaled;
    logic [WIDE_BITS:0]   rounded;
    logic [WIDE_BITS-1:0] b_d;
    atlb_pkg::tag_t       b_tag_next;

    assign q_pop   = advance && q_valid;
    assign a_write = advance && a_valid_reg;

    atlb_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (1 << ADDR_W)
    ) u_legacy_ram (
        .aclk    (aclk),
        .wr_en   (a_write),
        .wr_addr (a_addr_reg),
        .wr_data (a_lsum),
        .rd_en   (q_pop),
        .rd_addr (q_addr),
        .rd_data (l_rd_data)
    );

    atlb_ram #(
        .WIDTH (WIDE_BITS),
        .DEPTH (1 << ADDR_W)
    ) u_wide_ram (
        .aclk    (aclk),
        .wr_en   (a_write && a_item_reg.wide_on),
        .wr_addr (a_addr_reg),
        .wr_data (a_w),
        .rd_en   (q_pop),
        .rd_addr (q_addr),
        .rd_data (w_rd_data)
    );

    always_comb begin
        old_l  = fwd_l_hit_reg ? fwd_l_reg : l_rd_data;
        old_w  = fwd_w_hit_reg ? fwd_w_reg : w_rd_data;
        l_sum  = {1'b0, (a_item_reg.first ? {BYTE_W{1'b0}} : old_l)} +
                 {1'b0, a_item_reg.layer};
        a_lsum = l_sum[BYTE_W] ? atlb_pkg::BYTE_MAX : l_sum[BYTE_W-1:0];
        w_sum  = {1'b0, (a_item_reg.first ? {WIDE_BITS{1'b0}} : old_w)} +
                 (WIDE_BITS+1)'(a_item_reg.prod);
        w_sat  = w_sum[WIDE_BITS] ? '1 : w_sum[WIDE_BITS-1:0];
        a_w    = (a_item_reg.alpha && (w_sat > WHITE)) ? WHITE : w_sat;
    end

    always_comb begin
        legacy_scaled = WIDE_BITS'({b_lsum_reg, 7'b0});
        rounded       = ((WIDE_BITS+1)'(b_w_reg) + (WIDE_BITS+1)'(atlb_pkg::ROUND_HALF))
                        >> atlb_pkg::LAYER_SHIFT;
        b_d           = (b_w_reg > legacy_scaled) ? b_w_reg - legacy_scaled
                                                  : legacy_scaled - b_w_reg;
        b_tag_next         = b_tag_reg;
        b_tag_next.over    = (b_w_reg > WHITE);
        b_tag_next.differs = (rounded != (WIDE_BITS+1)'(b_lsum_reg));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            fwd_l_hit_reg <= 1'b0;
            fwd_w_hit_reg <= 1'b0;
        end else if (advance) begin
            a_valid_reg <= q_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            if (q_valid) begin
                fwd_l_hit_reg <= a_valid_reg && (a_addr_reg == q_addr);
                fwd_w_hit_reg <= a_valid_reg && (a_addr_reg == q_addr)
                                 && a_item_reg.wide_on;
            end
        end
        if (q_pop) begin
            a_item_reg <= q_item;
            a_addr_reg <= q_addr;
            fwd_l_reg  <= a_lsum;
            fwd_w_reg  <= a_w;
        end
        if (advance) begin
            b_tag_reg.wide_on <= a_item_reg.wide_on;
            b_tag_reg.alpha   <= a_item_reg.alpha;
            b_tag_reg.last    <= a_item_reg.last;
            b_tag_reg.over    <= 1'b0;
            b_tag_reg.differs <= 1'b0;
            b_lsum_reg        <= a_lsum;
            b_w_reg           <= a_item_reg.wide_on ? a_w : '0;
            c_tag_reg         <= b_tag_next;
            c_lsum_reg        <= b_lsum_reg;
            c_w_reg           <= b_w_reg;
            c_d_reg           <= b_d;
        end
    end

    assign c_valid = c_valid_reg;
    assign c_tag   = c_tag_reg;
    assign c_lsum  = c_lsum_reg;
    assign c_w     = c_w_reg;
    assign c_d     = c_d_reg;

endmodule

// ===== sv/atlb_stats.sv =====
`timescale 1ns / 1ps

module atlb_stats #(
    parameter int WIDE_BITS = 24
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            c_valid,
    input  atlb_pkg::tag_t                  c_tag,
    input  logic [atlb_pkg::BYTE_W-1:0]     c_lsum,
    input  logic [WIDE_BITS-1:0]            c_w,
    input  logic [WIDE_BITS-1:0]            c_d,
    output logic                            advance,
    input  logic                            m_tready,
    output logic                            m_tvalid,
    output logic [atlb_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                            m_tuser
);

    localparam int COUNT_W = atlb_pkg::COUNT_W;
    localparam int OUT_W   = atlb_pkg::OUT_WIDE_W;
    localparam int EXT_W   = (WIDE_BITS > OUT_W) ? WIDE_BITS : OUT_W;

    logic [COUNT_W-1:0]   over_cnt_reg;
    logic [COUNT_W-1:0]   diff_cnt_reg;
    logic [WIDE_BITS-1:0] max_wide_reg;
    logic [WIDE_BITS-1:0] max_dev_reg;
    logic                 m_tvalid_reg;
    logic [atlb_pkg::M_TDATA_W-1:0] m_tdata_reg;
    logic                 m_tuser_reg;

    logic                 contrib;
    logic [COUNT_W-1:0]   over_cnt_next;
    logic [COUNT_W-1:0]   diff_cnt_next;
    logic [WIDE_BITS-1:0] max_wide_next;
    logic [WIDE_BITS-1:0] max_dev_next;
    logic                 stats_valid_next;
    logic [EXT_W-1:0]     w_ext;
    logic [EXT_W-1:0]     max_wide_ext;
    logic [EXT_W-1:0]     max_dev_ext;
    logic [atlb_pkg::M_TDATA_W-1:0] m_tdata_next;

    assign advance = !m_tvalid_reg || m_tready;
    assign contrib = c_tag.wide_on && !c_tag.alpha;

    always_comb begin
        over_cnt_next = over_cnt_reg;
        diff_cnt_next = diff_cnt_reg;
        if (contrib && c_tag.over && (over_cnt_reg != atlb_pkg::COUNT_MAX)) begin
            over_cnt_next = over_cnt_reg + COUNT_W'(1);
        end
        if (contrib && c_tag.differs && (diff_cnt_reg != atlb_pkg::COUNT_MAX)) begin
            diff_cnt_next = diff_cnt_reg + COUNT_W'(1);
        end
        max_wide_next    = (contrib && (c_w > max_wide_reg)) ? c_w : max_wide_reg;
        max_dev_next     = (contrib && (c_d > max_dev_reg)) ? c_d : max_dev_reg;
        stats_valid_next = c_tag.wide_on && c_tag.last;

        w_ext        = EXT_W'(c_w);
        max_wide_ext = stats_valid_next ? EXT_W'(max_wide_next) : '0;
        max_dev_ext  = stats_valid_next ? EXT_W'(max_dev_next) : '0;
        m_tdata_next = {4'b0,
                        max_dev_ext[OUT_W-1:0],
                        max_wide_ext[OUT_W-1:0],
                        (stats_valid_next ? diff_cnt_next : {COUNT_W{1'b0}}),
                        (stats_valid_next ? over_cnt_next : {COUNT_W{1'b0}}),
                        w_ext[OUT_W-1:0],
                        c_lsum};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
            over_cnt_reg <= '0;
            diff_cnt_reg <= '0;
            max_wide_reg <= '0;
            max_dev_reg  <= '0;
        end else if (advance) begin
            m_tvalid_reg <= c_valid;
            if (c_valid) begin
                if (c_tag.last) begin
                    over_cnt_reg <= '0;
                    diff_cnt_reg <= '0;
                    max_wide_reg <= '0;
                    max_dev_reg  <= '0;
                end else begin
                    over_cnt_reg <= over_cnt_next;
                    diff_cnt_reg <= diff_cnt_next;
                    max_wide_reg <= max_wide_next;
                    max_dev_reg  <= max_dev_next;
                end
            end
        end
        if (advance && c_valid) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= stats_valid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule
